// ===== hdl/iptp_pkg.sv =====
// Shared types, codes and helpers for the address text parser.
// No dependencies; used by iptp_ctrl, iptp_dp and the top level.
`timescale 1ns / 1ps

package iptp_pkg;

    localparam int MAX_TEXT_LEN_DEF = 64;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_DOT   = 8'h2E;
    localparam logic [7:0] CHR_SLASH = 8'h2F;

    localparam logic [2:0] ST_V4_ADDR  = 3'd0;
    localparam logic [2:0] ST_V4_NET   = 3'd1;
    localparam logic [2:0] ST_V6_ADDR  = 3'd2;
    localparam logic [2:0] ST_V6_NET   = 3'd3;
    localparam logic [2:0] ST_BAD_ADDR = 3'd4;
    localparam logic [2:0] ST_BAD_MASK = 3'd5;

    typedef enum logic [3:0] {
        PH_START, PH_LEAD, PH_GROUP, PH_SEP, PH_DBL, PH_V4, PH_MASK, PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE, ERR_ADDR, ERR_MASK
    } t_err;

    typedef enum logic [1:0] {
        OUT_ADDR, OUT_MASK, OUT_ERR_ADDR, OUT_ERR_MASK
    } t_out;

    typedef struct packed {
        t_phase phase;
        logic   count;
        logic   start_grp;
        logic   hex_shift;
        logic   dec_shift;
        logic   push_left;
        logic   push_right;
        logic   set_v6;
        logic   set_dbl;
        logic   v4_first;
        logic   v4_dot;
        logic   to_mask;
        logic   mask_dot;
        logic   load_out;
        t_out   out_sel;
        logic   clear;
    } t_cmd;

    typedef struct packed {
        logic [2:0] dc;
        logic       gi_lt8;
        logic       has_dbl;
        logic       rc_lt6;
        logic       oct_ok;
        logic       v4_dot_ok;
        logic       cmp_ok;
        logic       mask_dot_ok;
        logic       fin_mask_ok;
        logic       over;
        logic       out_busy;
    } t_stat;

    function automatic logic is_dec_chr(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex_chr(input logic [7:0] c);
        return is_dec_chr(c) || ((c >= 8'h61) && (c <= 8'h66))
            || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_of(input logic [7:0] c);
        logic [7:0] v;
        if (is_dec_chr(c)) begin
            v = c - 8'h30;
        end else if (c >= 8'h61) begin
            v = c - 8'h57;
        end else begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    // {valid, bit count} of one mask octet
    function automatic logic [4:0] mask_bits(input logic [7:0] o);
        logic [4:0] r;
        case (o)
            8'd0:    r = {1'b1, 4'd0};
            8'd128:  r = {1'b1, 4'd1};
            8'd192:  r = {1'b1, 4'd2};
            8'd224:  r = {1'b1, 4'd3};
            8'd240:  r = {1'b1, 4'd4};
            8'd248:  r = {1'b1, 4'd5};
            8'd252:  r = {1'b1, 4'd6};
            8'd254:  r = {1'b1, 4'd7};
            8'd255:  r = {1'b1, 4'd8};
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/iptp_ctrl.sv =====
// Parse controller: phase state machine, error tracking and end-of-text sequencing.
// Depends on iptp_pkg; drives iptp_dp through t_cmd and reads t_stat.
`timescale 1ns / 1ps

module iptp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_char,
    input  logic            i_last,
    output logic            o_ready,
    input  iptp_pkg::t_stat i_stat,
    output iptp_pkg::t_cmd  o_cmd
);

    iptp_pkg::t_phase r_phase, n_phase;
    iptp_pkg::t_err   r_err, n_err;
    logic             r_fin, n_fin;
    logic             w_accept, w_dec, w_hex, w_fail_a, w_fail_m;

    assign o_ready  = !r_fin && !i_stat.out_busy;
    assign w_accept = i_valid && o_ready;
    assign w_dec    = iptp_pkg::is_dec_chr(i_char);
    assign w_hex    = iptp_pkg::is_hex_chr(i_char);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= iptp_pkg::PH_START;
            r_err   <= iptp_pkg::ERR_NONE;
            r_fin   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_err   <= n_err;
            r_fin   <= n_fin;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_err   = r_err;
        n_fin   = r_fin;
        w_fail_a = 1'b0;
        w_fail_m = 1'b0;
        o_cmd = '0;
        o_cmd.phase   = r_phase;
        o_cmd.out_sel = iptp_pkg::OUT_ERR_ADDR;
        if (r_fin) begin
            o_cmd.load_out = 1'b1;
            o_cmd.clear    = 1'b1;
            if (r_err == iptp_pkg::ERR_MASK) begin
                o_cmd.out_sel = iptp_pkg::OUT_ERR_MASK;
            end else if (r_err == iptp_pkg::ERR_ADDR) begin
                o_cmd.out_sel = iptp_pkg::OUT_ERR_ADDR;
            end else if (r_phase == iptp_pkg::PH_MASK) begin
                o_cmd.out_sel = i_stat.fin_mask_ok ? iptp_pkg::OUT_MASK
                                                   : iptp_pkg::OUT_ERR_MASK;
            end else begin
                o_cmd.out_sel = i_stat.cmp_ok ? iptp_pkg::OUT_ADDR
                                              : iptp_pkg::OUT_ERR_ADDR;
            end
            n_phase = iptp_pkg::PH_START;
            n_err   = iptp_pkg::ERR_NONE;
            n_fin   = 1'b0;
        end else if (w_accept) begin
            if (i_char != iptp_pkg::CHR_NUL) begin
                o_cmd.count = 1'b1;
                if (i_stat.over) begin
                    w_fail_a = 1'b1;
                end else begin
                    case (r_phase)
                        iptp_pkg::PH_START: begin
                            if (i_char == iptp_pkg::CHR_COLON) begin
                                n_phase = iptp_pkg::PH_LEAD;
                            end else if (w_hex) begin
                                o_cmd.start_grp = 1'b1;
                                n_phase = iptp_pkg::PH_GROUP;
                            end else begin
                                w_fail_a = 1'b1;
                            end
                        end
                        iptp_pkg::PH_LEAD: begin
                            if (i_char == iptp_pkg::CHR_COLON) begin
                                o_cmd.set_v6  = 1'b1;
                                o_cmd.set_dbl = 1'b1;
                                n_phase = iptp_pkg::PH_DBL;
                            end else begin
                                w_fail_a = 1'b1;
                            end
                        end
                        iptp_pkg::PH_SEP, iptp_pkg::PH_DBL: begin
                            if (w_hex) begin
                                o_cmd.start_grp = 1'b1;
                                n_phase = iptp_pkg::PH_GROUP;
                            end else if (i_char == iptp_pkg::CHR_COLON
                                         && r_phase == iptp_pkg::PH_SEP
                                         && !i_stat.has_dbl) begin
                                o_cmd.set_dbl = 1'b1;
                                n_phase = iptp_pkg::PH_DBL;
                            end else if (i_char == iptp_pkg::CHR_SLASH
                                         && r_phase == iptp_pkg::PH_DBL
                                         && i_stat.cmp_ok) begin
                                o_cmd.to_mask = 1'b1;
                                n_phase = iptp_pkg::PH_MASK;
                            end else begin
                                w_fail_a = 1'b1;
                            end
                        end
                        iptp_pkg::PH_GROUP: begin
                            if (w_hex) begin
                                if (i_stat.dc >= 3'd4) begin
                                    w_fail_a = 1'b1;
                                end else begin
                                    o_cmd.hex_shift = 1'b1;
                                end
                            end else if (i_char == iptp_pkg::CHR_COLON) begin
                                if (!i_stat.has_dbl && i_stat.gi_lt8) begin
                                    o_cmd.push_left = 1'b1;
                                    n_phase = iptp_pkg::PH_SEP;
                                end else if (i_stat.has_dbl && i_stat.rc_lt6) begin
                                    o_cmd.push_right = 1'b1;
                                    n_phase = iptp_pkg::PH_SEP;
                                end else begin
                                    w_fail_a = 1'b1;
                                end
                            end else if (i_char == iptp_pkg::CHR_DOT && i_stat.oct_ok) begin
                                o_cmd.v4_first = 1'b1;
                                n_phase = iptp_pkg::PH_V4;
                            end else if (i_char == iptp_pkg::CHR_SLASH && i_stat.cmp_ok) begin
                                o_cmd.to_mask = 1'b1;
                                n_phase = iptp_pkg::PH_MASK;
                            end else begin
                                w_fail_a = 1'b1;
                            end
                        end
                        iptp_pkg::PH_V4: begin
                            if (w_dec) begin
                                if (i_stat.dc >= 3'd3) begin
                                    w_fail_a = 1'b1;
                                end else begin
                                    o_cmd.dec_shift = 1'b1;
                                end
                            end else if (i_char == iptp_pkg::CHR_DOT && i_stat.v4_dot_ok) begin
                                o_cmd.v4_dot = 1'b1;
                            end else if (i_char == iptp_pkg::CHR_SLASH && i_stat.cmp_ok) begin
                                o_cmd.to_mask = 1'b1;
                                n_phase = iptp_pkg::PH_MASK;
                            end else begin
                                w_fail_a = 1'b1;
                            end
                        end
                        iptp_pkg::PH_MASK: begin
                            if (w_dec) begin
                                if (i_stat.dc >= 3'd3) begin
                                    w_fail_m = 1'b1;
                                end else begin
                                    o_cmd.dec_shift = 1'b1;
                                end
                            end else if (i_char == iptp_pkg::CHR_DOT
                                         && i_stat.mask_dot_ok) begin
                                o_cmd.mask_dot = 1'b1;
                            end else begin
                                w_fail_m = 1'b1;
                            end
                        end
                        iptp_pkg::PH_ERROR: begin
                            n_phase = iptp_pkg::PH_ERROR;
                        end
                        default: begin
                            w_fail_a = 1'b1;
                        end
                    endcase
                end
            end
            if (w_fail_a || w_fail_m) begin
                // first error wins; drop the rest of the text
                if (r_err == iptp_pkg::ERR_NONE) begin
                    n_err = w_fail_m ? iptp_pkg::ERR_MASK : iptp_pkg::ERR_ADDR;
                end
                n_phase = iptp_pkg::PH_ERROR;
                o_cmd.start_grp  = 1'b0;
                o_cmd.hex_shift  = 1'b0;
                o_cmd.dec_shift  = 1'b0;
                o_cmd.push_left  = 1'b0;
                o_cmd.push_right = 1'b0;
                o_cmd.v4_first   = 1'b0;
                o_cmd.v4_dot     = 1'b0;
                o_cmd.to_mask    = 1'b0;
                o_cmd.mask_dot   = 1'b0;
            end
            if (i_char == iptp_pkg::CHR_NUL || i_last) begin
                n_fin = 1'b1;
            end
        end
    end

    a_fin_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> (r_phase == iptp_pkg::PH_START && r_err == iptp_pkg::ERR_NONE))
        else $error("phase not restarted after result");
    a_err_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == iptp_pkg::PH_ERROR) |-> (r_err != iptp_pkg::ERR_NONE))
        else $error("error phase without error code");
    a_err_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != iptp_pkg::ERR_NONE) |-> (r_phase == iptp_pkg::PH_ERROR))
        else $error("error code outside error phase");

endmodule

// ===== hdl/iptp_dp.sv =====
// Parse datapath: group and octet assembly, group stores, mask checks, address
// alignment and the result register. Depends on iptp_pkg; driven by iptp_ctrl.
`timescale 1ns / 1ps

module iptp_dp #(
    parameter int MAX_TEXT_LEN = iptp_pkg::MAX_TEXT_LEN_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_char,
    input  iptp_pkg::t_cmd  i_cmd,
    output iptp_pkg::t_stat o_stat,
    input  logic            i_m_ready,
    output logic            o_m_valid,
    output logic [2:0]      o_status,
    output logic [63:0]     o_addr_high,
    output logic [63:0]     o_addr_low,
    output logic [7:0]      o_prefix_len
);

    logic [15:0]  r_gv;
    logic [2:0]   r_dc;
    logic [3:0]   r_gi;
    logic [15:0]  r_left [8];
    logic [15:0]  r_right [6];
    logic [2:0]   r_rc;
    logic [7:0]   r_v4 [3];
    logic [1:0]   r_v4i;
    logic [7:0]   r_total;
    logic [7:0]   r_prev;
    logic [7:0]   r_cc;
    logic         r_v6, r_dbl;
    logic [1:0]   r_dots;
    logic [127:0] r_done;
    logic         r_ov;
    logic [2:0]   r_status;
    logic [127:0] r_addr;
    logic [7:0]   r_plen;

    logic [8:0]   w_cc_next;
    logic [3:0]   w_hex;
    logic [15:0]  w_dec_gv;
    logic [9:0]   w_oct;
    logic         w_oct_ok;
    logic [4:0]   w_mb;
    logic         w_take_ok;
    logic         w_v4ok, w_base_ok, w_cnt_ok, w_cmp_ok;
    logic [3:0]   w_tl, w_off;
    logic [4:0]   w_sum;
    logic [15:0]  w_tail [8];
    logic [15:0]  w_g [8];
    logic [127:0] w_cmp_addr;
    logic [7:0]   w_fin_len;
    logic         w_fin_ok;

    assign w_cc_next = (r_cc == 8'hFF) ? {1'b0, r_cc} : {1'b0, r_cc} + 9'd1;
    assign w_hex     = iptp_pkg::hex_of(i_char);
    assign w_dec_gv  = (r_gv << 3) + (r_gv << 1) + {8'd0, i_char - 8'h30};

    // hex nibbles of the group read as a decimal octet
    always_comb begin
        w_oct_ok = (r_dc >= 3'd1) && (r_dc <= 3'd3) && (r_gv[3:0] <= 4'd9);
        w_oct    = {6'd0, r_gv[3:0]};
        if (r_dc >= 3'd2) begin
            w_oct_ok = w_oct_ok && (r_gv[7:4] <= 4'd9);
            w_oct    = w_oct + 10'(r_gv[7:4] * 4'd10);
        end
        if (r_dc == 3'd3) begin
            w_oct_ok = w_oct_ok && (r_gv[11:8] <= 4'd9);
            w_oct    = w_oct + 10'(r_gv[11:8] * 7'd100);
        end
        w_oct_ok = w_oct_ok && (w_oct <= 10'd255);
    end

    assign w_mb      = iptp_pkg::mask_bits(r_gv[7:0]);
    assign w_take_ok = (r_gv <= 16'd255) && w_mb[4]
                     && !(r_dots != 2'd0 && r_prev != 8'd255 && r_gv != 16'd0);

    always_comb begin
        w_fin_ok  = 1'b0;
        w_fin_len = r_total + {4'd0, w_mb[3:0]};
        if (r_dc != 3'd0) begin
            if (r_dots == 2'd0) begin
                w_fin_ok  = r_gv <= (r_v6 ? 16'd128 : 16'd32);
                w_fin_len = r_gv[7:0];
            end else begin
                w_fin_ok = (r_dots == 2'd3) && w_take_ok;
            end
        end
    end

    // address completion: place the groups after '::' at the right end
    always_comb begin
        w_v4ok = (r_dc != 3'd0) && (r_gv <= 16'd255) && (r_v4i == 2'd3);
        case (i_cmd.phase)
            iptp_pkg::PH_V4:    w_tl = {1'b0, r_rc} + 4'd2;
            iptp_pkg::PH_GROUP: w_tl = {1'b0, r_rc} + 4'd1;
            default:            w_tl = {1'b0, r_rc};
        endcase
        w_off = 4'd8 - w_tl;
        w_sum = {1'b0, r_gi} + {1'b0, w_tl};
        w_cnt_ok = r_dbl ? (w_sum <= 5'd7) : (w_sum == 5'd8);
        case (i_cmd.phase)
            iptp_pkg::PH_V4:    w_base_ok = w_v4ok;
            iptp_pkg::PH_GROUP: w_base_ok = r_v6;
            iptp_pkg::PH_DBL:   w_base_ok = 1'b1;
            default:            w_base_ok = 1'b0;
        endcase
        for (int k = 0; k < 8; k++) begin
            w_tail[k] = 16'd0;
            if (k < 6 && 3'(k) < r_rc) begin
                w_tail[k] = r_right[(k < 6) ? k : 0];
            end else if (3'(k) == r_rc) begin
                w_tail[k] = (i_cmd.phase == iptp_pkg::PH_V4) ? {r_v4[0], r_v4[1]} : r_gv;
            end else if (4'(k) == {1'b0, r_rc} + 4'd1) begin
                w_tail[k] = {r_v4[2], r_gv[7:0]};
            end
        end
        for (int j = 0; j < 8; j++) begin
            if (4'(j) >= w_off) begin
                w_g[j] = w_tail[3'(4'(j) - w_off)];
            end else if (4'(j) < r_gi) begin
                w_g[j] = r_left[j];
            end else begin
                w_g[j] = 16'd0;
            end
        end
        if (i_cmd.phase == iptp_pkg::PH_V4 && !r_v6) begin
            w_cmp_ok   = w_v4ok;
            w_cmp_addr = {96'd0, r_v4[0], r_v4[1], r_v4[2], r_gv[7:0]};
        end else begin
            w_cmp_ok   = w_base_ok && w_cnt_ok;
            w_cmp_addr = {w_g[0], w_g[1], w_g[2], w_g[3], w_g[4], w_g[5], w_g[6], w_g[7]};
        end
    end

    always_comb begin
        o_stat.dc          = r_dc;
        o_stat.gi_lt8      = r_gi < 4'd8;
        o_stat.has_dbl     = r_dbl;
        o_stat.rc_lt6      = r_rc < 3'd6;
        o_stat.oct_ok      = w_oct_ok;
        o_stat.v4_dot_ok   = (r_dc != 3'd0) && (r_gv <= 16'd255) && (r_v4i < 2'd3);
        o_stat.cmp_ok      = w_cmp_ok;
        o_stat.mask_dot_ok = (r_dc != 3'd0) && (r_dots < 2'd3) && w_take_ok;
        o_stat.fin_mask_ok = w_fin_ok;
        o_stat.over        = w_cc_next > 9'(MAX_TEXT_LEN);
        o_stat.out_busy    = r_ov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_gv    <= '0;
            r_dc    <= '0;
            r_gi    <= '0;
            r_rc    <= '0;
            r_v4i   <= '0;
            r_total <= '0;
            r_prev  <= '0;
            r_cc    <= '0;
            r_v6    <= 1'b0;
            r_dbl   <= 1'b0;
            r_dots  <= '0;
            r_done  <= '0;
        end else begin
            if (i_cmd.count) begin
                r_cc <= w_cc_next[7:0];
            end
            if (i_cmd.set_v6) begin
                r_v6 <= 1'b1;
            end
            if (i_cmd.set_dbl) begin
                r_dbl <= 1'b1;
            end
            if (i_cmd.start_grp) begin
                r_gv <= {12'd0, w_hex};
                r_dc <= 3'd1;
            end
            if (i_cmd.hex_shift) begin
                r_gv <= {r_gv[11:0], w_hex};
                r_dc <= r_dc + 3'd1;
            end
            if (i_cmd.dec_shift) begin
                r_gv <= w_dec_gv;
                r_dc <= r_dc + 3'd1;
            end
            if (i_cmd.push_left) begin
                r_left[r_gi[2:0]] <= r_gv;
                r_gi <= r_gi + 4'd1;
                r_v6 <= 1'b1;
                r_gv <= '0;
                r_dc <= '0;
            end
            if (i_cmd.push_right) begin
                r_right[r_rc] <= r_gv;
                r_rc <= r_rc + 3'd1;
                r_v6 <= 1'b1;
                r_gv <= '0;
                r_dc <= '0;
            end
            if (i_cmd.v4_first) begin
                r_v4[0] <= w_oct[7:0];
                r_v4i   <= 2'd1;
                r_gv    <= '0;
                r_dc    <= '0;
            end
            if (i_cmd.v4_dot) begin
                r_v4[r_v4i] <= r_gv[7:0];
                r_v4i <= r_v4i + 2'd1;
                r_gv  <= '0;
                r_dc  <= '0;
            end
            if (i_cmd.to_mask) begin
                r_done <= w_cmp_addr;
                r_gv   <= '0;
                r_dc   <= '0;
            end
            if (i_cmd.mask_dot) begin
                r_total <= r_total + {4'd0, w_mb[3:0]};
                r_prev  <= r_gv[7:0];
                r_dots  <= r_dots + 2'd1;
                r_gv    <= '0;
                r_dc    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ov <= 1'b1;
        end else if (i_m_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            case (i_cmd.out_sel)
                iptp_pkg::OUT_ADDR: begin
                    r_status <= r_v6 ? iptp_pkg::ST_V6_ADDR : iptp_pkg::ST_V4_ADDR;
                    r_addr   <= w_cmp_addr;
                    r_plen   <= r_v6 ? 8'd128 : 8'd32;
                end
                iptp_pkg::OUT_MASK: begin
                    r_status <= r_v6 ? iptp_pkg::ST_V6_NET : iptp_pkg::ST_V4_NET;
                    r_addr   <= r_done;
                    r_plen   <= w_fin_len;
                end
                iptp_pkg::OUT_ERR_MASK: begin
                    r_status <= iptp_pkg::ST_BAD_MASK;
                    r_addr   <= '0;
                    r_plen   <= '0;
                end
                default: begin
                    r_status <= iptp_pkg::ST_BAD_ADDR;
                    r_addr   <= '0;
                    r_plen   <= '0;
                end
            endcase
        end
    end

    assign o_m_valid    = r_ov;
    assign o_status     = r_status;
    assign o_addr_high  = r_addr[127:64];
    assign o_addr_low   = r_addr[63:0];
    assign o_prefix_len = r_plen;

    a_dc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dc <= 3'd4)
        else $error("digit count out of range");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_m_ready) |-> !i_cmd.load_out)
        else $error("result overwritten while pending");
    a_groups_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gi <= 4'd8) && (r_rc <= 3'd6))
        else $error("group count out of range");

endmodule

// ===== hdl/ip_prefix_text_parser_top.sv =====
// Top level of the IPv4/IPv6 address text parser.
// Depends on iptp_pkg, iptp_ctrl and iptp_dp.
`timescale 1ns / 1ps

//  channel   dir  handshake              payload
//  s (text)  in   i_s_tvalid/o_s_tready  i_s_tdata = char_code, i_s_tlast = is_last
//  m (res)   out  o_m_tvalid/i_m_tready  o_m_tdata = status, addr_high, addr_low,
//                                         prefix_len
//
// One character beat is taken per cycle while parsing. A beat with tlast set
// or a NUL character ends the text; the block then registers the end of the
// text, aligns the groups and loads the result register. The next text is
// taken once the result beat has left. Reset is synchronous, active low, and
// clears the parse state but for the group and octet stores, and it drops the
// pending result.

module ip_prefix_text_parser_top #(
    parameter int MAX_TEXT_LEN = iptp_pkg::MAX_TEXT_LEN_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] char_code
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [143:0] o_m_tdata    // [2:0] status, [66:3] addr_high,
                                      // [130:67] addr_low, [138:131] prefix_len
);

    iptp_pkg::t_cmd  w_cmd;
    iptp_pkg::t_stat w_stat;
    logic [2:0]      w_status;
    logic [63:0]     w_high, w_low;
    logic [7:0]      w_plen;

    // controller: phase machine, error latch, end-of-text handling
    iptp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_char  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_ready (o_s_tready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // datapath: group stores, checks, alignment and result register
    iptp_dp #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char       (i_s_tdata),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_m_ready    (i_m_tready),
        .o_m_valid    (o_m_tvalid),
        .o_status     (w_status),
        .o_addr_high  (w_high),
        .o_addr_low   (w_low),
        .o_prefix_len (w_plen)
    );

    // pack the result beat, low field first, zero fill to whole bytes
    assign o_m_tdata = {5'd0, w_plen, w_low, w_high, w_status};

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for ip_prefix_text_parser_top: streams address texts,
// predicts each parse result and compares every result beat field by field.
// Depends on iptp_pkg and the parser RTL.
`timescale 1ns / 1ps

module testbench;
    import iptp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TEXT_LEN_MAX = MAX_TEXT_LEN_DEF;
    localparam int RANDOM_TEXTS = 950;

    typedef struct {
        logic [2:0]  status;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [7:0]  prefix_len;
    } t_parse_res;

    // how a text is closed: tlast on its last character, or a NUL after it, with or without tlast
    typedef enum {END_LAST, END_NUL, END_NUL_LAST} t_end;

    typedef struct {
        string      txt;
        t_end       close;
        bit         typed;
        t_parse_res res;
    } t_text_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [7:0]   s_tdata = 8'd0;
    logic         s_tlast = 1'b0;
    logic         m_tready = 1'b0;
    wire          s_tready;
    wire          m_tvalid;
    wire  [143:0] m_tdata;

    t_parse_res   res_q[$];          // parse results still to come out
    int           errors = 0;
    int           cyc = 0;
    int           burst_left = 0;
    int           hold_cnt = 0;

    // parser state as the predictor sees it
    t_phase       ph;
    t_err         err;
    logic [15:0]  gv;
    logic [15:0]  lg[8];
    logic [15:0]  rg[6];
    logic [7:0]   v4o[4];
    logic [7:0]   mtot;
    logic [7:0]   pmo;
    logic [63:0]  done_hi;
    logic [63:0]  done_lo;
    int           dc, gi, rc, v4i, mdots, cc;
    bit           v6, dbl;

    always #10 i_clk = ~i_clk;

    ip_prefix_text_parser_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),      // [7:0] char_code
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)       // [2:0] status, [66:3] addr_high,
                                    // [130:67] addr_low, [138:131] prefix_len
    );

    // ------------------------------------------------------------------
    // Parse predictor
    // ------------------------------------------------------------------
    function void clear_parse();
        ph = PH_START;
        err = ERR_NONE;
        gv = 16'd0;
        for (int i = 0; i < 8; i++) lg[i] = 16'd0;
        for (int i = 0; i < 6; i++) rg[i] = 16'd0;
        for (int i = 0; i < 4; i++) v4o[i] = 8'd0;
        mtot = 8'd0;
        pmo = 8'd0;
        done_hi = 64'd0;
        done_lo = 64'd0;
        dc = 0; gi = 0; rc = 0; v4i = 0; mdots = 0; cc = 0;
        v6 = 1'b0;
        dbl = 1'b0;
    endfunction

    function int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    // first error wins; the phase still drops to the error sink
    function void set_fail(input t_err e);
        if (err == ERR_NONE) err = e;
        ph = PH_ERROR;
    endfunction

    // hex nibbles typed so far, reread as a decimal octet
    function bit group_octet(output int o);
        int d, nb;
        d = 0;
        o = 0;
        if (dc < 1 || dc > 3) return 0;
        for (int i = dc; i > 0; i--) begin
            nb = (gv >> (4 * (i - 1))) & 15;
            if (nb > 9) return 0;
            d = d * 10 + nb;
        end
        if (d > 255) return 0;
        o = d;
        return 1;
    endfunction

    // align groups around '::' and latch the finished address
    function bit address_done();
        logic [15:0] tail[8];
        logic [15:0] g[8];
        int tl;
        tl = 0;
        if (ph == PH_V4) begin
            if (dc == 0 || gv > 255 || v4i != 3) return 0;
            v4o[3] = gv[7:0];
            if (!v6) begin
                done_hi = 64'd0;
                done_lo = {32'd0, v4o[0], v4o[1], v4o[2], v4o[3]};
                return 1;
            end
        end else if (ph == PH_GROUP) begin
            if (!v6) return 0;
        end else if (ph != PH_DBL) begin
            return 0;
        end
        for (int i = 0; i < rc && i < 6; i++) begin
            tail[tl] = rg[i];
            tl++;
        end
        if (ph == PH_GROUP) begin
            tail[tl] = gv;
            tl++;
        end else if (ph == PH_V4) begin
            tail[tl] = {v4o[0], v4o[1]};
            tail[tl + 1] = {v4o[2], v4o[3]};
            tl += 2;
        end
        if (dbl ? (gi + tl > 7) : (gi + tl != 8)) return 0;
        for (int i = 0; i < 8; i++) g[i] = 16'd0;
        for (int i = 0; i < gi && i < 8; i++) g[i] = lg[i];
        for (int i = 0; i < tl; i++) g[(8 - tl + i) & 7] = tail[i];
        done_hi = {g[0], g[1], g[2], g[3]};
        done_lo = {g[4], g[5], g[6], g[7]};
        return 1;
    endfunction

    // one dotted mask octet: allowed value, and contiguous with the previous
    function bit mask_octet_ok();
        int bits;
        case (gv)
            16'd0:   bits = 0;
            16'd128: bits = 1;
            16'd192: bits = 2;
            16'd224: bits = 3;
            16'd240: bits = 4;
            16'd248: bits = 5;
            16'd252: bits = 6;
            16'd254: bits = 7;
            16'd255: bits = 8;
            default: return 0;
        endcase
        if (mdots > 0 && pmo != 8'd255 && gv != 16'd0) return 0;
        mtot = mtot + bits;
        pmo = gv[7:0];
        return 1;
    endfunction

    function bit mask_done();
        if (dc == 0) return 0;
        if (mdots == 0) begin
            if (gv > (v6 ? 128 : 32)) return 0;
            mtot = gv[7:0];
            return 1;
        end
        if (mdots != 3 || gv > 255) return 0;
        return mask_octet_ok();
    endfunction

    function void enter_mask();
        if (address_done()) begin
            ph = PH_MASK;
            gv = 16'd0;
            dc = 0;
        end else begin
            set_fail(ERR_ADDR);
        end
    endfunction

    function void begin_group(input int h);
        gv = h;
        dc = 1;
        ph = PH_GROUP;
    endfunction

    function void take_char(input logic [7:0] c);
        int h;
        int oct;
        bit isdec;
        h = hex_digit(c);
        isdec = (c >= "0" && c <= "9");
        if (cc < 255) cc++;
        if (cc > TEXT_LEN_MAX) set_fail(ERR_ADDR);
        if (ph == PH_ERROR) return;
        case (ph)
            PH_START: begin
                if (c == CHR_COLON) ph = PH_LEAD;
                else if (h >= 0) begin_group(h);
                else set_fail(ERR_ADDR);
            end
            PH_LEAD: begin
                if (c == CHR_COLON) begin
                    v6 = 1'b1;
                    dbl = 1'b1;
                    ph = PH_DBL;
                end else begin
                    set_fail(ERR_ADDR);
                end
            end
            PH_SEP, PH_DBL: begin
                if (h >= 0) begin
                    begin_group(h);
                end else if (c == CHR_COLON && ph == PH_SEP && !dbl) begin
                    dbl = 1'b1;
                    ph = PH_DBL;
                end else if (c == CHR_SLASH && ph == PH_DBL) begin
                    enter_mask();
                end else begin
                    set_fail(ERR_ADDR);
                end
            end
            PH_GROUP: begin
                if (h >= 0) begin
                    if (dc >= 4) begin
                        set_fail(ERR_ADDR);
                        return;
                    end
                    gv = (gv << 4) | h;
                    dc++;
                end else if (c == CHR_COLON) begin
                    if (!dbl && gi < 8) begin
                        lg[gi & 7] = gv;
                        gi++;
                    end else if (dbl && rc < 6) begin
                        rg[rc] = gv;
                        rc++;
                    end else begin
                        set_fail(ERR_ADDR);
                        return;
                    end
                    v6 = 1'b1;
                    gv = 16'd0;
                    dc = 0;
                    ph = PH_SEP;
                end else if (c == CHR_DOT) begin
                    if (!group_octet(oct)) begin
                        set_fail(ERR_ADDR);
                        return;
                    end
                    v4o[0] = oct;
                    v4i = 1;
                    gv = 16'd0;
                    dc = 0;
                    ph = PH_V4;
                end else if (c == CHR_SLASH) begin
                    enter_mask();
                end else begin
                    set_fail(ERR_ADDR);
                end
            end
            PH_V4: begin
                if (isdec) begin
                    if (dc >= 3) begin
                        set_fail(ERR_ADDR);
                        return;
                    end
                    gv = gv * 16'd10 + (c - "0");
                    dc++;
                end else if (c == CHR_DOT) begin
                    if (dc == 0 || gv > 255 || v4i >= 3) begin
                        set_fail(ERR_ADDR);
                        return;
                    end
                    v4o[v4i & 3] = gv[7:0];
                    v4i++;
                    gv = 16'd0;
                    dc = 0;
                end else if (c == CHR_SLASH) begin
                    enter_mask();
                end else begin
                    set_fail(ERR_ADDR);
                end
            end
            PH_MASK: begin
                if (isdec) begin
                    if (dc >= 3) begin
                        set_fail(ERR_MASK);
                        return;
                    end
                    gv = gv * 16'd10 + (c - "0");
                    dc++;
                end else if (c == CHR_DOT) begin
                    if (dc == 0 || mdots >= 3 || gv > 255 || !mask_octet_ok()) begin
                        set_fail(ERR_MASK);
                        return;
                    end
                    mdots++;
                    gv = 16'd0;
                    dc = 0;
                end else begin
                    set_fail(ERR_MASK);
                end
            end
            default: set_fail(ERR_ADDR);
        endcase
    endfunction

    // advance the predictor by one character beat; queue a result when the text ends
    function void predict_beat(input logic [7:0] c, input bit last);
        t_parse_res r;
        if (c != CHR_NUL) take_char(c);
        if (c != CHR_NUL && !last) return;
        r = '{3'd0, 64'd0, 64'd0, 8'd0};
        if (err == ERR_NONE) begin
            if (ph == PH_MASK) begin
                if (mask_done()) begin
                    r.status = v6 ? ST_V6_NET : ST_V4_NET;
                    r.prefix_len = mtot;
                end else begin
                    set_fail(ERR_MASK);
                end
            end else if (address_done()) begin
                r.status = v6 ? ST_V6_ADDR : ST_V4_ADDR;
                r.prefix_len = v6 ? 8'd128 : 8'd32;
            end else begin
                set_fail(ERR_ADDR);
            end
        end
        if (err != ERR_NONE) begin
            r = '{(err == ERR_MASK) ? ST_BAD_MASK : ST_BAD_ADDR, 64'd0, 64'd0, 8'd0};
        end else begin
            r.addr_high = done_hi;
            r.addr_low = done_lo;
        end
        res_q.push_back(r);
        clear_parse();
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    task send_beat(input logic [7:0] c, input bit last);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 20);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= last;
        do @(posedge i_clk); while (!s_tready);
        burst_left--;
    endtask

    task send_text(input string txt, input t_end close, input bit typed,
                   input t_parse_res typed_res);
        bit last;
        int n;
        n = txt.len();
        if (n == 0 && close == END_LAST) close = END_NUL_LAST;
        for (int i = 0; i < n; i++) begin
            last = (close == END_LAST) && (i == n - 1);
            predict_beat(txt[i], last);
            send_beat(txt[i], last);
        end
        if (close != END_LAST) begin
            predict_beat(CHR_NUL, close == END_NUL_LAST);
            send_beat(CHR_NUL, close == END_NUL_LAST);
        end
        // hand-typed rows replace the predicted result
        if (typed) begin
            void'(res_q.pop_back());
            res_q.push_back(typed_res);
        end
    endtask

    // ------------------------------------------------------------------
    // Random text builders
    // ------------------------------------------------------------------
    function string hex_group();
        string s;
        int nb;
        s = "";
        for (int i = $urandom_range(1, 4); i > 0; i--) begin
            nb = $urandom_range(0, 15);
            if (nb < 10) s = {s, $sformatf("%c", "0" + nb)};
            else s = {s, $sformatf("%c", ($urandom_range(0, 1) ? "a" : "A") + nb - 10)};
        end
        return s;
    endfunction

    function string dec_octet();
        int v;
        v = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) ? 255 : 0))
                                        : $urandom_range(0, 255);
        if ($urandom_range(0, 30) == 0) v = $urandom_range(256, 999);
        if ($urandom_range(0, 9) == 0) return $sformatf("%03d", v);
        return $sformatf("%0d", v);
    endfunction

    function string v4_text();
        return {dec_octet(), ".", dec_octet(), ".", dec_octet(), ".", dec_octet()};
    endfunction

    function string v6_text();
        string s;
        int k, left_n;
        bit tail, use_dbl;
        s = "";
        use_dbl = $urandom_range(0, 1);
        tail = ($urandom_range(0, 4) == 0);
        if (use_dbl) begin
            k = $urandom_range(0, tail ? 5 : 7);
            left_n = $urandom_range(0, k);
            for (int i = 0; i < left_n; i++) s = {s, hex_group(), (i < left_n - 1) ? ":" : ""};
            s = {s, "::"};
            for (int i = left_n; i < k; i++) s = {s, hex_group(), (i < k - 1) ? ":" : ""};
            if (tail) s = {s, (k > left_n) ? ":" : "", v4_text()};
        end else begin
            k = tail ? 6 : 8;
            for (int i = 0; i < k; i++) s = {s, hex_group(), (i < k - 1) ? ":" : ""};
            if (tail) s = {s, ":", v4_text()};
        end
        return s;
    endfunction

    function string mask_text(input bit is6);
        int allowed[9] = '{0, 128, 192, 224, 240, 248, 252, 254, 255};
        logic [31:0] m;
        int p;
        case ($urandom_range(0, 4))
            0, 1: return "";
            2: begin
                p = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, is6 ? 128 : 32);
                return $sformatf("/%0d", p);
            end
            default: begin
                p = $urandom_range(0, 32);
                m = (p == 0) ? 32'd0 : ~32'd0 << (32 - p);
                if ($urandom_range(0, 5) == 0)
                    m[8 * $urandom_range(0, 3) +: 8] = allowed[$urandom_range(0, 8)];
                return $sformatf("/%0d.%0d.%0d.%0d", m[31:24], m[23:16], m[15:8], m[7:0]);
            end
        endcase
    endfunction

    function string noise_char();
        string alpha;
        alpha = "0123456789abcdefABCDEF:./xg ";
        if ($urandom_range(0, 7) == 0) return $sformatf("%c", $urandom_range(1, 255));
        return $sformatf("%c", alpha[$urandom_range(0, alpha.len() - 1)]);
    endfunction

    function string random_text();
        string s;
        int pos;
        bit is6;
        is6 = $urandom_range(0, 1);
        s = is6 ? v6_text() : v4_text();
        s = {s, mask_text(is6)};
        case ($urandom_range(0, 19))
            0, 1, 2: begin                        // one character spoiled
                pos = $urandom_range(0, s.len() - 1);
                s = {s.substr(0, pos - 1), noise_char(), s.substr(pos + 1, s.len() - 1)};
            end
            3, 4: s = s.substr(0, $urandom_range(0, s.len() - 1));     // cut short
            5, 6: begin                           // pure noise
                s = "";
                for (int i = $urandom_range(1, 10); i > 0; i--) s = {s, noise_char()};
            end
            7: begin                              // overlong
                s = "";
                for (int i = 0; i < 34; i++) s = {s, "1:"};
            end
            default: ;
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Directed rows: extremes, every status and the error cases
    // ------------------------------------------------------------------
    t_parse_res no_res = '{3'd0, 64'd0, 64'd0, 8'd0};
    t_parse_res bad_addr = '{ST_BAD_ADDR, 64'd0, 64'd0, 8'd0};
    t_parse_res bad_mask = '{ST_BAD_MASK, 64'd0, 64'd0, 8'd0};

    t_text_row dir_tab[] = '{
        '{"0.0.0.0", END_LAST, 1, '{ST_V4_ADDR, 64'd0, 64'd0, 8'd32}},
        '{"255.255.255.255", END_LAST, 1,
          '{ST_V4_ADDR, 64'd0, 64'h0000_0000_ffff_ffff, 8'd32}},
        '{"10.0.0.0/8", END_LAST, 1, '{ST_V4_NET, 64'd0, 64'h0a00_0000, 8'd8}},
        '{"192.168.1.0/255.255.255.0", END_LAST, 1,
          '{ST_V4_NET, 64'd0, 64'hc0a8_0100, 8'd24}},
        '{"::", END_LAST, 1, '{ST_V6_ADDR, 64'd0, 64'd0, 8'd128}},
        '{"ffff:FFFF:ffff:ffff:ffff:ffff:ffff:ffff", END_LAST, 1,
          '{ST_V6_ADDR, ~64'd0, ~64'd0, 8'd128}},
        '{"::/0", END_LAST, 1, '{ST_V6_NET, 64'd0, 64'd0, 8'd0}},
        '{"1::/128", END_LAST, 1, '{ST_V6_NET, 64'h0001_0000_0000_0000, 64'd0, 8'd128}},
        '{"::ffff:1.2.3.4", END_LAST, 1,
          '{ST_V6_ADDR, 64'd0, 64'h0000_ffff_0102_0304, 8'd128}},
        '{"", END_NUL_LAST, 1, bad_addr},
        '{"/24", END_LAST, 1, bad_addr},
        '{"1.2.3.256", END_LAST, 1, bad_addr},
        '{"12345::", END_LAST, 1, bad_addr},
        '{":1::", END_LAST, 1, bad_addr},
        '{"1:::2", END_LAST, 1, bad_addr},
        '{"1::2::3", END_LAST, 1, bad_addr},
        '{"1:2:3:4:5:6:7", END_LAST, 1, bad_addr},
        '{"1:2:3:4:5:6:7::8", END_LAST, 1, bad_addr},
        '{"1:", END_LAST, 1, bad_addr},
        '{"1.2.3.4/33", END_LAST, 1, bad_mask},
        '{"1.2.3.4/", END_LAST, 1, bad_mask},
        '{"1.2.3.4/255.0.255.0", END_LAST, 1, bad_mask},
        '{"1.2.3.4/255.255.0", END_LAST, 1, bad_mask},
        '{"1::/129", END_LAST, 1, bad_mask},
        '{"1.2.3.4/1x", END_LAST, 1, bad_mask},
        '{"1:2:3:4:5:6:7:8:1:2:3:4:5:6:7:8:1:2:3:4:5:6:7:8:1:2:3:4:5:6:7:8:1",
          END_LAST, 1, bad_addr},
        '{"1.2.3.4", END_NUL, 0, no_res},
        '{"2001:db8::1:2.3.4.5/64", END_NUL_LAST, 0, no_res}
    };

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        clear_parse();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_tab[i])
            send_text(dir_tab[i].txt, dir_tab[i].close, dir_tab[i].typed, dir_tab[i].res);
        // hold the sender until every result has drained
        s_tvalid <= 1'b0;
        while (res_q.size() != 0) @(posedge i_clk);
        for (int i = 0; i < RANDOM_TEXTS; i++) begin
            case ($urandom_range(0, 19))
                0:       send_text(random_text(), END_NUL, 0, no_res);
                1:       send_text(random_text(), END_NUL_LAST, 0, no_res);
                default: send_text(random_text(), END_LAST, 0, no_res);
            endcase
        end
        s_tvalid <= 1'b0;
        while (res_q.size() != 0) @(posedge i_clk);
        // the block aligns the groups in the cycle after the last beat
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern rotates among always ready, random and mostly stalled, plus one long hold-off
    // ------------------------------------------------------------------
    task report(input string what, input logic [63:0] want, input logic [63:0] got);
        $display("mismatch at cycle %0d: %s expected %0h got %0h", cyc, what, want, got);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_parse_res want;
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (res_q.size() == 0) begin
                    report("unexpected result, status", 64'd0, m_tdata[2:0]);
                end else begin
                    want = res_q.pop_front();
                    if (m_tdata[2:0] !== want.status)
                        report("status", want.status, m_tdata[2:0]);
                    if (m_tdata[66:3] !== want.addr_high)
                        report("addr_high", want.addr_high, m_tdata[66:3]);
                    if (m_tdata[130:67] !== want.addr_low)
                        report("addr_low", want.addr_low, m_tdata[130:67]);
                    if (m_tdata[138:131] !== want.prefix_len)
                        report("prefix_len", want.prefix_len, m_tdata[138:131]);
                end
            end
            // one long hold-off early in the random part, while texts keep coming
            if (cyc == 3000) hold_cnt <= 400;
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end else begin
                case ((cyc / 64) % 3)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

endmodule
